// ===== rtl/core/plti_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the piecewise linear table interpolator.
// No dependencies; every other file in rtl/core imports this package.
package plti_pkg;

    localparam int MAX_POINTS  = 16;
    localparam int NCNT_W      = $clog2(MAX_POINTS + 1);
    localparam int DATA_W      = 32;
    localparam int STEP_W      = $clog2(DATA_W);
    localparam int ENTRY_IDX_W = 4;
    localparam int PU_W        = 5;

    // Input word layout, lowest bit first.
    localparam int IDX_LSB   = 0;
    localparam int EX_LSB    = IDX_LSB + ENTRY_IDX_W;
    localparam int EY_LSB    = EX_LSB + DATA_W;
    localparam int QX_LSB    = EY_LSB + DATA_W;
    localparam int IN_BITS   = QX_LSB + DATA_W;
    localparam int IN_W      = ((IN_BITS + 7) / 8) * 8;

    localparam logic KIND_WRITE = 1'b0;
    localparam logic KIND_QUERY = 1'b1;

    localparam logic [1:0] REG_BELOW  = 2'd0;
    localparam logic [1:0] REG_ABOVE  = 2'd1;
    localparam logic [1:0] REG_EXACT  = 2'd2;
    localparam logic [1:0] REG_INTERP = 2'd3;

    // Query token that walks the cell row.
    typedef struct packed {
        logic              valid;
        logic              below;
        logic              found;
        logic [1:0]        region;
        logic [DATA_W-1:0] q;
        logic [DATA_W-1:0] px;
        logic [DATA_W-1:0] py;
        logic [DATA_W-1:0] x0;
        logic [DATA_W-1:0] x1;
        logic [DATA_W-1:0] y;
        logic [DATA_W-1:0] y1;
    } t_tok;

    typedef struct packed {
        logic wr_en;
        logic first;
        logic active;
        logic last;
    } t_cell_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_lerp_stat;

endpackage

// ===== rtl/core/plti_cell.sv =====
`timescale 1ns / 1ps
// One breakpoint cell: holds one (x, y) pair and advances the query token by one stage.
// Depends on plti_pkg.
module plti_cell
    import plti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cell_ctl         i_ctl,
    input  logic [DATA_W-1:0] i_wr_x,
    input  logic [DATA_W-1:0] i_wr_y,
    input  t_tok              i_tok,
    output t_tok              o_tok
);

    logic [DATA_W-1:0] r_x;
    logic [DATA_W-1:0] r_y;
    t_tok              r_tok;
    t_tok              n_tok;
    logic              ge;
    logic              eq;

    assign ge = $signed(r_x) >= $signed(i_tok.q);
    assign eq = r_x == i_tok.q;

    always_comb begin
        n_tok    = i_tok;
        n_tok.px = r_x;
        n_tok.py = r_y;
        if (i_ctl.first && ge && !eq) begin
            n_tok.below  = 1'b1;
            n_tok.found  = 1'b1;
            n_tok.region = REG_BELOW;
            n_tok.y      = r_y;
        end else if (i_ctl.active && !i_tok.found && ge) begin
            n_tok.found = 1'b1;
            if (eq) begin
                n_tok.region = REG_EXACT;
                n_tok.y      = r_y;
            end else begin
                n_tok.region = REG_INTERP;
                n_tok.x0     = i_tok.px;
                n_tok.y      = i_tok.py;
                n_tok.x1     = r_x;
                n_tok.y1     = r_y;
            end
        end
        // Beyond the last breakpoint in use the last y wins over any earlier match.
        if (i_ctl.last && !n_tok.below && !ge) begin
            n_tok.found  = 1'b1;
            n_tok.region = REG_ABOVE;
            n_tok.y      = r_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_x <= i_wr_x;
            r_y <= i_wr_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tok.valid <= 1'b0;
        end else begin
            r_tok <= n_tok;
        end
    end

    assign o_tok = r_tok;

endmodule

// ===== rtl/core/plti_lerp.sv =====
`timescale 1ns / 1ps
// Serial interpolation unit: shift-add multiply, then restoring divide, one bit per cycle.
// Depends on plti_pkg.
module plti_lerp
    import plti_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_tok              i_tok,
    input  logic              i_take,
    output t_lerp_stat        o_stat,
    output logic [DATA_W-1:0] o_y,
    output logic [1:0]        o_region
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PREP = 6'b000010,
        ST_MUL  = 6'b000100,
        ST_DIV  = 6'b001000,
        ST_FIN  = 6'b010000,
        ST_DONE = 6'b100000
    } t_lerp_st;

    t_lerp_st          r_state, n_state;
    logic [STEP_W-1:0] r_cnt, n_cnt;
    logic [DATA_W-1:0] r_q, r_x0, r_x1, r_y0, r_y1;
    logic [DATA_W-1:0] n_q, n_x0, n_x1, n_y0, n_y1;
    logic [DATA_W-1:0] r_dx, r_den, r_hi, r_lo;
    logic [DATA_W-1:0] n_dx, n_den, n_hi, n_lo;
    logic              r_neg, n_neg;
    logic [1:0]        r_region, n_region;
    logic [DATA_W:0]   mul_sum;
    logic [DATA_W:0]   div_t;
    logic [DATA_W:0]   div_diff;
    logic              div_ge;
    logic              last_step;

    assign mul_sum   = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_dx} : '0);
    assign div_t     = {r_hi, r_lo[DATA_W-1]};
    assign div_diff  = div_t - {1'b0, r_den};
    assign div_ge    = div_t >= {1'b0, r_den};
    assign last_step = r_cnt == STEP_W'(DATA_W - 1);

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        n_q      = r_q;
        n_x0     = r_x0;
        n_x1     = r_x1;
        n_y0     = r_y0;
        n_y1     = r_y1;
        n_dx     = r_dx;
        n_den    = r_den;
        n_hi     = r_hi;
        n_lo     = r_lo;
        n_neg    = r_neg;
        n_region = r_region;
        unique case (r_state)
            ST_IDLE: begin
                if (i_tok.valid) begin
                    n_q      = i_tok.q;
                    n_x0     = i_tok.x0;
                    n_x1     = i_tok.x1;
                    n_y0     = i_tok.y;
                    n_y1     = i_tok.y1;
                    n_region = i_tok.region;
                    n_state  = (i_tok.region == REG_INTERP) ? ST_PREP : ST_DONE;
                end
            end
            ST_PREP: begin
                // Both differences are positive here, so 32 bits hold them exactly.
                n_dx    = r_q - r_x0;
                n_den   = r_x1 - r_x0;
                n_neg   = $signed(r_y1) < $signed(r_y0);
                n_lo    = n_neg ? (r_y0 - r_y1) : (r_y1 - r_y0);
                n_hi    = '0;
                n_cnt   = '0;
                n_state = ST_MUL;
            end
            ST_MUL: begin
                n_hi  = mul_sum[DATA_W:1];
                n_lo  = {mul_sum[0], r_lo[DATA_W-1:1]};
                n_cnt = r_cnt + 1'b1;
                if (last_step) begin
                    n_state = ST_DIV;
                end
            end
            ST_DIV: begin
                // The high half of the product is already below the divisor.
                n_hi  = div_ge ? div_diff[DATA_W-1:0] : div_t[DATA_W-1:0];
                n_lo  = {r_lo[DATA_W-2:0], div_ge};
                n_cnt = r_cnt + 1'b1;
                if (last_step) begin
                    n_state = ST_FIN;
                end
            end
            ST_FIN: begin
                n_y0    = r_neg ? (r_y0 - r_lo) : (r_y0 + r_lo);
                n_state = ST_DONE;
            end
            ST_DONE: begin
                if (i_take) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        r_q      <= n_q;
        r_x0     <= n_x0;
        r_x1     <= n_x1;
        r_y0     <= n_y0;
        r_y1     <= n_y1;
        r_dx     <= n_dx;
        r_den    <= n_den;
        r_hi     <= n_hi;
        r_lo     <= n_lo;
        r_neg    <= n_neg;
        r_region <= n_region;
    end

    assign o_stat.busy = r_state != ST_IDLE;
    assign o_stat.done = r_state == ST_DONE;
    assign o_y         = r_y0;
    assign o_region    = r_region;

endmodule

// ===== rtl/core/piecewise_linear_table_interpolator.sv =====
`timescale 1ns / 1ps
// Top level of the piecewise linear table interpolator: breakpoint cell row,
// serial interpolation unit and output register. Depends on plti_pkg, plti_cell, plti_lerp.
//
//   Channel  Direction  Payload
//   s_axis   in         tdata: entry_index, entry_x, entry_y, query_x; tuser: kind
//   m_axis   out        tdata: out_y; tuser: region
//   cfg      in         i_cfg_wdata: points_used, written when i_cfg_we is high
//
// A query word walks all MAX_POINTS cells, one per cycle, and an interpolated one then goes
// through the serial multiply and divide unit; a clamped or exact one passes it unchanged.
// s_axis_tready is low while a query is in flight; a result waiting in the output
// register does not hold off the next word. Reset clears the control state only;
// the breakpoint table holds no value until written.
module piecewise_linear_table_interpolator
    import plti_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_cfg_we,
    input  logic [PU_W-1:0]  i_cfg_wdata,
    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [IN_W-1:0]  s_axis_tdata,   // entry_index, entry_x, entry_y, query_x, pad
    input  logic             s_axis_tuser,   // kind
    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,  // out_y
    output logic [1:0]       m_axis_tuser    // region
);

    logic [PU_W-1:0]        r_points_used;
    logic [NCNT_W-1:0]      n_eff;
    logic                   r_busy;
    logic                   r_m_valid;
    logic [DATA_W-1:0]      r_m_data;
    logic [1:0]             r_m_user;
    logic                   in_acc;
    logic                   acc_write;
    logic                   acc_query;
    logic                   take;
    logic [ENTRY_IDX_W-1:0] entry_index;
    logic [DATA_W-1:0]      entry_x;
    logic [DATA_W-1:0]      entry_y;
    logic [DATA_W-1:0]      query_x;
    t_tok                   tok [MAX_POINTS+1];
    t_cell_ctl              ctl [MAX_POINTS];
    logic [MAX_POINTS-1:0]  chain_valid;
    t_lerp_stat             lerp_stat;
    logic [DATA_W-1:0]      lerp_y;
    logic [1:0]             lerp_region;

    assign entry_index = s_axis_tdata[IDX_LSB +: ENTRY_IDX_W];
    assign entry_x     = s_axis_tdata[EX_LSB +: DATA_W];
    assign entry_y     = s_axis_tdata[EY_LSB +: DATA_W];
    assign query_x     = s_axis_tdata[QX_LSB +: DATA_W];

    assign s_axis_tready = !r_busy;
    assign in_acc        = s_axis_tvalid && s_axis_tready;
    assign acc_write     = in_acc && (s_axis_tuser == KIND_WRITE);
    assign acc_query     = in_acc && (s_axis_tuser == KIND_QUERY);

    always_comb begin
        if (r_points_used == '0) begin
            n_eff = NCNT_W'(1);
        end else if (int'(r_points_used) > MAX_POINTS) begin
            n_eff = NCNT_W'(MAX_POINTS);
        end else begin
            n_eff = NCNT_W'(r_points_used);
        end
    end

    always_comb begin
        tok[0]        = '0;
        tok[0].valid  = acc_query;
        tok[0].region = REG_ABOVE;
        tok[0].q      = query_x;
    end

    for (genvar g = 0; g < MAX_POINTS; g++) begin : g_cell
        if (g < (1 << ENTRY_IDX_W)) begin : g_wr
            assign ctl[g].wr_en = acc_write && (entry_index == ENTRY_IDX_W'(g));
        end else begin : g_nowr
            assign ctl[g].wr_en = 1'b0;
        end
        assign ctl[g].first  = g == 0;
        assign ctl[g].active = NCNT_W'(g) < n_eff;
        assign ctl[g].last   = NCNT_W'(g) == (n_eff - 1'b1);
        assign chain_valid[g] = tok[g+1].valid;

        plti_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctl   (ctl[g]),
            .i_wr_x  (entry_x),
            .i_wr_y  (entry_y),
            .i_tok   (tok[g]),
            .o_tok   (tok[g+1])
        );
    end

    plti_lerp u_lerp (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tok    (tok[MAX_POINTS]),
        .i_take   (take),
        .o_stat   (lerp_stat),
        .o_y      (lerp_y),
        .o_region (lerp_region)
    );

    assign take = lerp_stat.done && (!r_m_valid || m_axis_tready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_points_used <= PU_W'(MAX_POINTS);
            r_busy        <= 1'b0;
            r_m_valid     <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_points_used <= i_cfg_wdata;
            end
            if (acc_query) begin
                r_busy <= 1'b1;
            end else if (take) begin
                r_busy <= 1'b0;
            end
            if (take) begin
                r_m_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_m_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_m_data <= lerp_y;
            r_m_user <= lerp_region;
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;
    assign m_axis_tuser  = r_m_user;

`ifndef SYNTH
    a_query_blocks_input : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        acc_query |=> !s_axis_tready)
        else $error("input still ready after a query word");

    a_single_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(chain_valid))
        else $error("more than one query token in the cell row");

    a_lerp_excl_chain : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        lerp_stat.busy |-> (chain_valid == '0))
        else $error("query token in the cell row while the interpolation unit is busy");

    a_busy_covers_work : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((chain_valid != '0) || lerp_stat.busy) |-> r_busy)
        else $error("input ready while a query is in flight");
`endif

endmodule

// ===== tb/sv/piecewise_linear_table_interpolator_tb.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for piecewise_linear_table_interpolator: a directed table, then
// random phases of table loads and queries, each phase with its own points_used and idling.
// Depends on plti_pkg and the RTL under rtl/core.
module piecewise_linear_table_interpolator_tb;
    import plti_pkg::*;

    localparam int SETTLE_CYCLES = 100;  // longer than one interpolated query
    localparam int HOLD_CYCLES   = 600;
    localparam int PHASES        = 22;
    localparam int BODY_WORDS    = 72;
    localparam logic signed [DATA_W-1:0] X_MIN = 32'sh8000_0000;
    localparam logic signed [DATA_W-1:0] X_MAX = 32'sh7FFF_FFFF;

    typedef struct {
        logic                     kind;
        logic [ENTRY_IDX_W-1:0]   slot;
        logic signed [DATA_W-1:0] bx;
        logic signed [DATA_W-1:0] by;
        logic signed [DATA_W-1:0] qx;
    } t_lut_word;

    typedef struct packed {
        logic [DATA_W-1:0] y;
        logic [1:0]        region;
    } t_lut_result;

    typedef struct {
        t_lut_word   w;
        logic        fixed;
        t_lut_result res;
    } t_dir_row;

    logic              i_clk         = 1'b0;
    logic              i_rst_n       = 1'b0;
    logic              i_cfg_we      = 1'b0;
    logic [PU_W-1:0]   i_cfg_wdata   = '0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [IN_W-1:0]   s_axis_tdata  = '0;
    logic              s_axis_tuser  = 1'b0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [DATA_W-1:0] m_axis_tdata;
    logic [1:0]        m_axis_tuser;

    // Shadow copy of the breakpoint table and the points_used register.
    logic signed [DATA_W-1:0] bp_x [MAX_POINTS];
    logic signed [DATA_W-1:0] bp_y [MAX_POINTS];
    logic [PU_W-1:0]          points_reg = 5'd16;

    t_lut_result pending_results [$];
    t_dir_row    dir_rows [$];
    t_lut_result rx_want;
    int          err_cnt        = 0;
    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    int          hold_req       = 0;
    int          hold_seen      = 0;
    int          hold_left      = 0;

    piecewise_linear_table_interpolator i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int active_points();
        int n;
        n = points_reg;
        if (n < 1) n = 1;
        if (n > MAX_POINTS) n = MAX_POINTS;
        return n;
    endfunction

    function automatic t_lut_result interpolate_at(logic signed [DATA_W-1:0] q);
        int                 n;
        bit                 hit;
        logic signed [63:0] x0, y0, dy;
        logic [63:0]        dx, den, mag, quo, full;
        t_lut_result        r;
        n = active_points();
        r.y = bp_y[n-1];
        r.region = REG_ABOVE;
        hit = 1'b0;
        if (q < bp_x[0]) begin
            r.y = bp_y[0];
            r.region = REG_BELOW;
        end else if (q <= bp_x[n-1]) begin
            // First slot whose x is not below q decides; all earlier x are below q,
            // so the divisor stays positive even for an unordered table.
            for (int k = 0; k < n; k++) begin
                if (!hit && q == bp_x[k]) begin
                    r.y = bp_y[k];
                    r.region = REG_EXACT;
                    hit = 1'b1;
                end else if (!hit && q < bp_x[k] && k > 0) begin
                    x0 = bp_x[k-1];
                    y0 = bp_y[k-1];
                    dx = q - x0;
                    den = bp_x[k] - x0;
                    dy = bp_y[k] - y0;
                    mag = (dy < 0) ? -dy : dy;
                    quo = (dx * mag) / den;
                    full = (dy < 0) ? y0 - quo : y0 + quo;
                    r.y = full[DATA_W-1:0];
                    r.region = REG_INTERP;
                    hit = 1'b1;
                end
            end
        end
        return r;
    endfunction

    // Queries aimed at each region of the current table.
    function automatic logic signed [DATA_W-1:0] pick_query();
        int     n, k;
        longint v, span;
        n = active_points();
        k = $urandom_range(n - 1);
        v = bp_x[k];
        case ($urandom_range(9))
            0: v = longint'(bp_x[0]) - 1 - $urandom_range(1000);
            1: v = longint'(bp_x[n-1]) + 1 + $urandom_range(1000);
            3, 4, 5: begin
                if (k < n - 1) begin
                    span = longint'(bp_x[k+1]) - bp_x[k];
                    if (span > 1) v = v + 1 + (longint'($urandom) % (span - 1));
                end
            end
            6: v = $urandom_range(1) ? v + 1 : v - 1;
            7, 8: v = longint'($signed($urandom));
            9: v = $urandom_range(1) ? X_MAX : X_MIN;
            default: ;
        endcase
        if (v < X_MIN) v = X_MIN;
        if (v > X_MAX) v = X_MAX;
        return v[DATA_W-1:0];
    endfunction

    task automatic add_row(input logic kind, input int slot, input logic [DATA_W-1:0] x,
                           input logic [DATA_W-1:0] y, input logic [DATA_W-1:0] q,
                           input logic fixed, input logic [DATA_W-1:0] ry,
                           input logic [1:0] rreg);
        t_dir_row row;
        row.w.kind = kind;
        row.w.slot = 4'(slot);
        row.w.bx = x;
        row.w.by = y;
        row.w.qx = q;
        row.fixed = fixed;
        row.res.y = ry;
        row.res.region = rreg;
        dir_rows.push_back(row);
    endtask

    // Offers one word and waits for it to be taken; leaves tvalid high on return.
    task automatic send_word(input t_lut_word w, input logic fixed, input t_lut_result res);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= w.kind;
        s_axis_tdata  <= {{(IN_W - IN_BITS){1'b0}}, w.qx, w.by, w.bx, w.slot};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        if (w.kind == KIND_WRITE) begin
            bp_x[w.slot] = w.bx;
            bp_y[w.slot] = w.by;
        end else begin
            pending_results.push_back(fixed ? res : interpolate_at(w.qx));
        end
    endtask

    task automatic drain_block(input int settle);
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (settle) @(posedge i_clk);
    endtask

    task automatic write_points(input logic [PU_W-1:0] v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        points_reg = v;
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_results.size() == 0) begin
                $error("result word with nothing pending: out_y %h region %0d",
                       m_axis_tdata, m_axis_tuser);
                err_cnt++;
            end else begin
                rx_want = pending_results.pop_front();
                if (m_axis_tdata !== rx_want.y) begin
                    $error("out_y: expected %h, actual %h", rx_want.y, m_axis_tdata);
                    err_cnt++;
                end
                if (m_axis_tuser !== rx_want.region) begin
                    $error("region: expected %0d, actual %0d", rx_want.region, m_axis_tuser);
                    err_cnt++;
                end
            end
        end
        if (hold_req != hold_seen) begin
            hold_seen     <= hold_req;
            hold_left     <= HOLD_CYCLES;
            m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left     <= hold_left - 1;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial begin : stim
        t_lut_word        w;
        t_lut_result      r0;
        logic [PU_W-1:0]  cfg;
        int               style;
        longint           run;
        r0 = '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full table with the field extremes at both ends, then edge queries.
        for (int k = 0; k < MAX_POINTS; k++) begin
            add_row(KIND_WRITE, k,
                    (k == 0) ? X_MIN : (k == MAX_POINTS - 1) ? X_MAX : 32'((k - 8) << 20),
                    (k == 0) ? X_MAX : (k == MAX_POINTS - 1) ? X_MIN : 32'(k << 16),
                    $urandom, 1'b0, '0, REG_BELOW);
        end
        add_row(KIND_QUERY, 0, $urandom, $urandom, X_MIN, 1'b1, X_MAX, REG_EXACT);
        add_row(KIND_QUERY, 9, $urandom, $urandom, X_MAX, 1'b1, X_MIN, REG_EXACT);
        add_row(KIND_QUERY, 3, $urandom, $urandom, 32'hFFB0_0000, 1'b1, 32'h0003_0000,
                REG_EXACT);
        add_row(KIND_QUERY, 5, $urandom, $urandom, 32'hFFB8_0000, 1'b0, '0, REG_BELOW);
        add_row(KIND_QUERY, 6, $urandom, $urandom, X_MIN + 1, 1'b0, '0, REG_BELOW);
        add_row(KIND_QUERY, 12, $urandom, $urandom, X_MAX - 1, 1'b0, '0, REG_BELOW);
        add_row(KIND_WRITE, 0, 32'hF000_0000, 32'h0000_1234, $urandom, 1'b0, '0, REG_BELOW);
        add_row(KIND_QUERY, 15, $urandom, $urandom, X_MIN, 1'b1, 32'h0000_1234, REG_BELOW);
        add_row(KIND_QUERY, 10, $urandom, $urandom, 32'hF000_0000, 1'b1, 32'h0000_1234,
                REG_EXACT);
        foreach (dir_rows[j]) send_word(dir_rows[j].w, dir_rows[j].fixed, dir_rows[j].res);

        for (int p = 0; p < PHASES; p++) begin
            drain_block(SETTLE_CYCLES);
            case (p)
                0: cfg = 5'd16;
                1: cfg = 5'd1;
                2: cfg = 5'd0;
                3: cfg = 5'd31;
                4: cfg = 5'd17;
                5: cfg = 5'd2;
                6: cfg = 5'd15;
                7: cfg = 5'd8;
                default: cfg = PU_W'($urandom_range(31));
            endcase
            write_points(cfg);
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct <= 0;  end
                1: begin send_idle_pct = 62; recv_stall_pct <= 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct <= 62; end
                default: begin send_idle_pct = 15; recv_stall_pct <= 15; end
            endcase

            // Reload the whole table: spread over the full range, dense ramps with
            // repeated x, medium ramps, or now and then no order at all.
            style = $urandom_range(9);
            run = longint'($signed($urandom)) >>> 2;
            for (int k = 0; k < MAX_POINTS; k++) begin
                w.kind = KIND_WRITE;
                w.slot = 4'(k);
                w.by = $urandom;
                w.qx = $urandom;
                if (style < 3) begin
                    w.bx = {4'(k) ^ 4'h8, 28'($urandom)};
                end else if (style < 6) begin
                    run = run + $urandom_range(4);
                    w.bx = run[DATA_W-1:0];
                end else if (style < 9) begin
                    run = run + $urandom_range(1 << 20);
                    w.bx = run[DATA_W-1:0];
                end else begin
                    w.bx = $urandom;
                end
                send_word(w, 1'b0, r0);
            end

            for (int i = 0; i < BODY_WORDS; i++) begin
                if (p % 8 == 4 && i == 10) hold_req <= hold_req + 1;
                if (p % 8 == 6 && i == 40) drain_block(0);
                w.slot = 4'($urandom_range(15));
                w.bx = $urandom;
                w.by = $urandom;
                if ($urandom_range(99) < 12) begin
                    w.kind = KIND_WRITE;
                    w.qx = $urandom;
                end else begin
                    w.kind = KIND_QUERY;
                    w.qx = pick_query();
                end
                send_word(w, 1'b0, r0);
            end
        end

        drain_block(SETTLE_CYCLES);
        if (err_cnt == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

    // A correct run ends well before this timeout even with every stall at its worst.
    initial begin
        #20_000_000;
        $display("simulation failed");
        $finish;
    end

endmodule
